// ===== src/overwriting_rx_ring_buffer_defines.svh =====
// Assertion macros for the overwriting receive ring buffer.
`ifndef OVERWRITING_RX_RING_BUFFER_DEFINES_SVH
`define OVERWRITING_RX_RING_BUFFER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define ORB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define ORB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/orb_pkg.sv =====
// Shared types and constants for the overwriting receive ring buffer.
package orb_pkg;

    localparam int CMD_W  = 3;
    localparam int DATA_W = 8;
    localparam int FILL_W = 7;

    typedef logic [CMD_W-1:0]  cmd_t;
    typedef logic [DATA_W-1:0] data_t;
    typedef logic [FILL_W-1:0] fill_t;

    localparam cmd_t CMD_PUSH     = 3'd0;
    localparam cmd_t CMD_POP      = 3'd1;
    localparam cmd_t CMD_PEEK_OLD = 3'd2;
    localparam cmd_t CMD_PEEK_NEW = 3'd3;
    localparam cmd_t CMD_FLUSH    = 3'd4;

endpackage

// ===== src/orb_cmd_if.sv =====
// Command channel: command code and received byte.
interface orb_cmd_if import orb_pkg::*; ();
    logic  valid;
    logic  ready;
    cmd_t  command;
    data_t received_byte;

    modport source (output valid, output command, output received_byte, input ready);
    modport sink   (input valid, input command, input received_byte, output ready);
endinterface

// ===== src/orb_rsp_if.sv =====
// Response channel: read byte, status, fill count and drop flag.
interface orb_rsp_if import orb_pkg::*; ();
    logic  valid;
    logic  ready;
    data_t read_data;
    logic  queue_status;
    fill_t fill_count;
    logic  oldest_dropped;

    modport source (output valid, output read_data, output queue_status,
                    output fill_count, output oldest_dropped, input ready);
    modport sink   (input valid, input read_data, input queue_status,
                    input fill_count, input oldest_dropped, output ready);
endinterface

// ===== src/orb_mem.sv =====
// Byte store: one write port, one registered read port.
module orb_mem import orb_pkg::*; #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  data_t         wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output data_t         rd_data
);

    data_t mem [DEPTH];
    data_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/overwriting_rx_ring_buffer.sv =====
// Overwriting receive ring buffer: byte FIFO with push, pop, peeks and flush.
//
//  channel | dir | payload                                              | accepted when
//  cmd     | in  | command, received_byte                               | valid & ready
//  rsp     | out | read_data, queue_status, fill_count, oldest_dropped  | valid & ready
//
// One transaction per cycle sustained while cmd.ready holds; results pass through the
// store read register, then the response register. Pointers and fill count update
// at accept. Reset clears pointers and marks the ring empty; the store is not cleared.
// cmd.ready drops only while the response register is full and not taken
// and a finished transaction waits behind it.
`include "overwriting_rx_ring_buffer_defines.svh"

module overwriting_rx_ring_buffer import orb_pkg::*; #(
    parameter int RING_DEPTH = 64
) (
    input  logic clk,
    input  logic rst_n,
    orb_cmd_if.sink   cmd,
    orb_rsp_if.source rsp
);

    localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX  = AW'(RING_DEPTH - 1);
    localparam logic [CW-1:0] FULL_FILL = CW'(RING_DEPTH);

    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [AW-1:0] head_inc, tail_inc;
    logic          ring_empty, ring_full;

    logic          accept, s1_move;
    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    data_t         mem_rd_data;
    logic          op_rd, op_status, op_drop;

    logic          s1_valid_reg;
    logic          s1_rd_reg;
    logic          s1_status_reg;
    logic          s1_drop_reg;
    fill_t         s1_fill_reg;

    logic          out_valid_reg;
    data_t         out_data_reg;
    logic          out_status_reg;
    fill_t         out_fill_reg;
    logic          out_drop_reg;

    assign s1_move   = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign cmd.ready = !s1_valid_reg || s1_move;
    assign accept    = cmd.valid && cmd.ready;

    assign ring_empty = (fill_reg == '0);
    assign ring_full  = (fill_reg == FULL_FILL);
    assign head_inc   = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
    assign tail_inc   = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        fill_next = fill_reg;
        wr_en     = 1'b0;
        wr_addr   = tail_reg;
        rd_en     = 1'b0;
        rd_addr   = head_reg;
        op_rd     = 1'b0;
        op_status = 1'b0;
        op_drop   = 1'b0;
        if (accept)
        begin
            case (cmd.command)
                CMD_PUSH:
                begin
                    wr_en = 1'b1;
                    if (ring_empty)
                    begin
                        head_next = '0;
                        tail_next = '0;
                        wr_addr   = '0;
                        fill_next = CW'(1);
                    end
                    else
                    begin
                        if (ring_full)
                        begin
                            head_next = head_inc;
                            op_drop   = 1'b1;
                        end
                        else
                        begin
                            fill_next = fill_reg + CW'(1);
                        end
                        tail_next = tail_inc;
                        wr_addr   = tail_inc;
                    end
                end
                CMD_POP:
                begin
                    if (ring_empty)
                    begin
                        op_status = 1'b1;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        op_rd   = 1'b1;
                        rd_addr = head_reg;
                        if (fill_reg == CW'(1))
                        begin
                            head_next = '0;
                            tail_next = '0;
                            fill_next = '0;
                        end
                        else
                        begin
                            head_next = head_inc;
                            fill_next = fill_reg - CW'(1);
                        end
                    end
                end
                CMD_PEEK_OLD:
                begin
                    if (ring_empty)
                    begin
                        op_status = 1'b1;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        op_rd   = 1'b1;
                        rd_addr = head_reg;
                    end
                end
                CMD_PEEK_NEW:
                begin
                    if (ring_empty)
                    begin
                        op_status = 1'b1;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        op_rd   = 1'b1;
                        rd_addr = tail_reg;
                    end
                end
                CMD_FLUSH:
                begin
                    head_next = '0;
                    tail_next = '0;
                    fill_next = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    orb_mem #(
        .DEPTH (RING_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (cmd.received_byte),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (mem_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            fill_reg <= fill_next;
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_rd_reg     <= op_rd;
            s1_status_reg <= op_status;
            s1_drop_reg   <= op_drop;
            s1_fill_reg   <= FILL_W'(fill_next);
        end
        if (s1_move)
        begin
            out_data_reg   <= s1_rd_reg ? mem_rd_data : '0;
            out_status_reg <= s1_status_reg;
            out_fill_reg   <= s1_fill_reg;
            out_drop_reg   <= s1_drop_reg;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.read_data      = out_data_reg;
    assign rsp.queue_status   = out_status_reg;
    assign rsp.fill_count     = out_fill_reg;
    assign rsp.oldest_dropped = out_drop_reg;

    `ORB_ASSERT_NOW(a_fill_range, 1'b1, fill_reg <= FULL_FILL, "fill count above ring depth")
    `ORB_ASSERT_NOW(a_empty_ptrs, ring_empty, (head_reg == '0) && (tail_reg == '0), "empty ring with nonzero pointers")
    `ORB_ASSERT_NEXT(a_push_fills, accept && (cmd.command == CMD_PUSH), fill_reg != '0, "ring empty after push")
    `ORB_ASSERT_NOW(a_drop_full, s1_valid_reg && s1_drop_reg, s1_fill_reg == FILL_W'(RING_DEPTH), "drop reported on a ring that is not full")
    `ORB_ASSERT_NOW(a_stall_hold, s1_valid_reg && out_valid_reg && !rsp.ready, !cmd.ready, "command taken while pipeline is blocked")

endmodule
